FILE: src/caw_pkg.sv
`timescale 1ns / 1ps

package caw_pkg;

  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned QuatFracBits  = 30;
  localparam int unsigned AddrWidth     = 5;
  localparam int unsigned NumStages     = 8;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [63:0] s64_t;

  localparam logic [2:0] RegRadius = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegAxis   = 3'd2;
  localparam logic [2:0] RegOffX   = 3'd3;
  localparam logic [2:0] RegOffY   = 3'd4;
  localparam logic [2:0] RegOffZ   = 3'd5;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam s64_t S32Max = 64'sd2147483647;
  localparam s64_t S32Min = -64'sd2147483648;
  localparam s32_t QOne   = 32'sd1073741824;
  localparam s32_t QNeg   = -32'sd1073741824;
  localparam s64_t MatOne = 64'sd1 <<< (2 * QuatFracBits);

  typedef struct packed {
    logic [30:0]        radius;
    logic [30:0]        height;
    logic [1:0]         axis;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic signed [31:0] off_z;
  } cfg_t;

  function automatic s32_t sat32(input s64_t v);
    s32_t r;
    if (v > S32Max) begin
      r = 32'sh7fffffff;
    end else if (v < S32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round half up, then floor.
  function automatic s64_t rnd_shift(input s64_t v, input int unsigned s);
    s64_t r;
    r = (v + (64'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

  function automatic s32_t coord_fin(input s64_t p);
    return sat32(rnd_shift(p, CoordFracBits));
  endfunction

  function automatic s32_t mat_fin(input s64_t v);
    s64_t r;
    s32_t m;
    r = rnd_shift(v, QuatFracBits);
    if (r > 64'(QOne)) begin
      m = QOne;
    end else if (r < 64'(QNeg)) begin
      m = QNeg;
    end else begin
      m = r[31:0];
    end
    return m;
  endfunction

  function automatic s32_t quat_clamp(input s32_t q);
    s32_t r;
    if (q > QOne) begin
      r = QOne;
    end else if (q < QNeg) begin
      r = QNeg;
    end else begin
      r = q;
    end
    return r;
  endfunction

endpackage

FILE: src/capsule_world_aabb_top.sv
`timescale 1ns / 1ps
// Channel | Handshake                     | Payload
// input   | in_valid_i / in_stall_o       | pos_*_i, quat_*_i, scale_*_i
// output  | out_valid_o / out_stall_i     | min_*_o, max_*_o
// config  | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Eight register stages; one transaction enters per cycle unless a stalled
// valid output holds the pipeline, and its box leaves from the last stage. Two of them
// hold the multipliers (scale and quaternion products, then matrix times end points).
// Reset clears the valid bits and loads the register defaults.
// A stall on a valid output holds the whole pipeline, so in_stall_o follows it.

module capsule_world_aabb_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [caw_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  input  logic signed [31:0]            quat_w_i,
  input  logic signed [31:0]            quat_x_i,
  input  logic signed [31:0]            quat_y_i,
  input  logic signed [31:0]            quat_z_i,
  input  logic signed [31:0]            scale_x_i,
  input  logic signed [31:0]            scale_y_i,
  input  logic signed [31:0]            scale_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            min_x_o,
  output logic signed [31:0]            min_y_o,
  output logic signed [31:0]            min_z_o,
  output logic signed [31:0]            max_x_o,
  output logic signed [31:0]            max_y_o,
  output logic signed [31:0]            max_z_o
);

  caw_pkg::cfg_t cfg;
  logic [1:0]    ax;
  logic          en;
  logic [caw_pkg::NumStages-1:0] vld_q, vld_d;

  caw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Axis code three falls back to Y.
  assign ax = (cfg.axis == caw_pkg::AxisX) ? caw_pkg::AxisX :
              ((cfg.axis == caw_pkg::AxisZ) ? caw_pkg::AxisZ : caw_pkg::AxisY);

  assign en         = !(vld_q[caw_pkg::NumStages-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[caw_pkg::NumStages-1];
  assign vld_d = {vld_q[caw_pkg::NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: capture, quaternion clamp, scale selection.
  caw_pkg::s32_t s1_pos_q [3];
  caw_pkg::s32_t s1_sc_q [3];
  caw_pkg::s32_t s1_qw_q, s1_qx_q, s1_qy_q, s1_qz_q, s1_rs_q, s1_hs_q;
  caw_pkg::s32_t s1_rs_d, s1_hs_d;

  always_comb begin
    case (ax)
      caw_pkg::AxisX: begin
        s1_rs_d = (scale_y_i > scale_z_i) ? scale_y_i : scale_z_i;
        s1_hs_d = scale_x_i;
      end
      caw_pkg::AxisZ: begin
        s1_rs_d = (scale_x_i > scale_y_i) ? scale_x_i : scale_y_i;
        s1_hs_d = scale_z_i;
      end
      default: begin
        s1_rs_d = (scale_x_i > scale_z_i) ? scale_x_i : scale_z_i;
        s1_hs_d = scale_y_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pos_q[0] <= pos_x_i;
      s1_pos_q[1] <= pos_y_i;
      s1_pos_q[2] <= pos_z_i;
      s1_sc_q[0]  <= scale_x_i;
      s1_sc_q[1]  <= scale_y_i;
      s1_sc_q[2]  <= scale_z_i;
      s1_qw_q     <= caw_pkg::quat_clamp(quat_w_i);
      s1_qx_q     <= caw_pkg::quat_clamp(quat_x_i);
      s1_qy_q     <= caw_pkg::quat_clamp(quat_y_i);
      s1_qz_q     <= caw_pkg::quat_clamp(quat_z_i);
      s1_rs_q     <= s1_rs_d;
      s1_hs_q     <= s1_hs_d;
    end
  end

  // Stage 2: raw products.
  caw_pkg::s32_t s2_pos_q [3];
  caw_pkg::s64_t s2_cen_q [3];
  caw_pkg::s64_t s2_sr_q, s2_sh_q;
  caw_pkg::s64_t s2_xx_q, s2_yy_q, s2_zz_q, s2_xy_q, s2_xz_q, s2_yz_q;
  caw_pkg::s64_t s2_wx_q, s2_wy_q, s2_wz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pos_q    <= s1_pos_q;
      s2_sr_q     <= $signed({1'b0, cfg.radius}) * s1_rs_q;
      s2_sh_q     <= $signed({1'b0, cfg.height}) * s1_hs_q;
      s2_cen_q[0] <= cfg.off_x * s1_sc_q[0];
      s2_cen_q[1] <= cfg.off_y * s1_sc_q[1];
      s2_cen_q[2] <= cfg.off_z * s1_sc_q[2];
      s2_xx_q     <= s1_qx_q * s1_qx_q;
      s2_yy_q     <= s1_qy_q * s1_qy_q;
      s2_zz_q     <= s1_qz_q * s1_qz_q;
      s2_xy_q     <= s1_qx_q * s1_qy_q;
      s2_xz_q     <= s1_qx_q * s1_qz_q;
      s2_yz_q     <= s1_qy_q * s1_qz_q;
      s2_wx_q     <= s1_qw_q * s1_qx_q;
      s2_wy_q     <= s1_qw_q * s1_qy_q;
      s2_wz_q     <= s1_qw_q * s1_qz_q;
    end
  end

  // Stage 3: round and saturate, form the rotation matrix.
  caw_pkg::s32_t s3_pos_q [3];
  caw_pkg::s32_t s3_cen_q [3];
  caw_pkg::s32_t s3_m_q [9];
  caw_pkg::s32_t s3_sr_q, s3_sh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pos_q <= s2_pos_q;
      s3_sr_q  <= caw_pkg::coord_fin(s2_sr_q);
      s3_sh_q  <= caw_pkg::coord_fin(s2_sh_q);
      for (int i = 0; i < 3; i++) begin
        s3_cen_q[i] <= caw_pkg::coord_fin(s2_cen_q[i]);
      end
      s3_m_q[0] <= caw_pkg::mat_fin(caw_pkg::MatOne - 2 * (s2_yy_q + s2_zz_q));
      s3_m_q[1] <= caw_pkg::mat_fin(2 * (s2_xy_q - s2_wz_q));
      s3_m_q[2] <= caw_pkg::mat_fin(2 * (s2_xz_q + s2_wy_q));
      s3_m_q[3] <= caw_pkg::mat_fin(2 * (s2_xy_q + s2_wz_q));
      s3_m_q[4] <= caw_pkg::mat_fin(caw_pkg::MatOne - 2 * (s2_xx_q + s2_zz_q));
      s3_m_q[5] <= caw_pkg::mat_fin(2 * (s2_yz_q - s2_wx_q));
      s3_m_q[6] <= caw_pkg::mat_fin(2 * (s2_xz_q - s2_wy_q));
      s3_m_q[7] <= caw_pkg::mat_fin(2 * (s2_yz_q + s2_wx_q));
      s3_m_q[8] <= caw_pkg::mat_fin(caw_pkg::MatOne - 2 * (s2_xx_q + s2_yy_q));
    end
  end

  // Stage 4: inner segment half-length.
  caw_pkg::s32_t s4_pos_q [3];
  caw_pkg::s32_t s4_cen_q [3];
  caw_pkg::s32_t s4_m_q [9];
  caw_pkg::s32_t s4_sr_q, s4_half_q;
  logic signed [33:0] seg_len;

  assign seg_len = 34'(s3_sh_q) - (34'(s3_sr_q) <<< 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_pos_q  <= s3_pos_q;
      s4_cen_q  <= s3_cen_q;
      s4_m_q    <= s3_m_q;
      s4_sr_q   <= s3_sr_q;
      s4_half_q <= seg_len[33] ? '0 : caw_pkg::sat32(64'(seg_len >>> 1));
    end
  end

  // Stage 5: segment end points in local space.
  caw_pkg::s32_t s5_pos_q [3];
  caw_pkg::s32_t s5_top_q [3];
  caw_pkg::s32_t s5_bot_q [3];
  caw_pkg::s32_t s5_m_q [9];
  caw_pkg::s32_t s5_sr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_pos_q <= s4_pos_q;
      s5_m_q   <= s4_m_q;
      s5_sr_q  <= s4_sr_q;
      for (int i = 0; i < 3; i++) begin
        if (2'(i) == ax) begin
          s5_top_q[i] <= caw_pkg::sat32(64'(s4_cen_q[i]) + 64'(s4_half_q));
          s5_bot_q[i] <= caw_pkg::sat32(64'(s4_cen_q[i]) - 64'(s4_half_q));
        end else begin
          s5_top_q[i] <= s4_cen_q[i];
          s5_bot_q[i] <= s4_cen_q[i];
        end
      end
    end
  end

  // Stage 6: matrix times end points.
  caw_pkg::s32_t s6_pos_q [3];
  caw_pkg::s64_t s6_pt_q [9];
  caw_pkg::s64_t s6_pb_q [9];
  caw_pkg::s32_t s6_sr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_pos_q <= s5_pos_q;
      s6_sr_q  <= s5_sr_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s6_pt_q[3*i+j] <= s5_m_q[3*i+j] * s5_top_q[j];
          s6_pb_q[3*i+j] <= s5_m_q[3*i+j] * s5_bot_q[j];
        end
      end
    end
  end

  // Stage 7: world end points.
  caw_pkg::s32_t s7_wt_q [3];
  caw_pkg::s32_t s7_wb_q [3];
  caw_pkg::s32_t s7_sr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_sr_q <= s6_sr_q;
      for (int i = 0; i < 3; i++) begin
        s7_wt_q[i] <= caw_pkg::sat32(caw_pkg::rnd_shift(
            s6_pt_q[3*i] + s6_pt_q[3*i+1] + s6_pt_q[3*i+2], caw_pkg::QuatFracBits)
            + 64'(s6_pos_q[i]));
        s7_wb_q[i] <= caw_pkg::sat32(caw_pkg::rnd_shift(
            s6_pb_q[3*i] + s6_pb_q[3*i+1] + s6_pb_q[3*i+2], caw_pkg::QuatFracBits)
            + 64'(s6_pos_q[i]));
      end
    end
  end

  // Stage 8: bound and pad by the scaled radius.
  caw_pkg::s32_t s8_min_q [3];
  caw_pkg::s32_t s8_max_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (s7_wt_q[i] < s7_wb_q[i]) begin
          s8_min_q[i] <= caw_pkg::sat32(64'(s7_wt_q[i]) - 64'(s7_sr_q));
          s8_max_q[i] <= caw_pkg::sat32(64'(s7_wb_q[i]) + 64'(s7_sr_q));
        end else begin
          s8_min_q[i] <= caw_pkg::sat32(64'(s7_wb_q[i]) - 64'(s7_sr_q));
          s8_max_q[i] <= caw_pkg::sat32(64'(s7_wt_q[i]) + 64'(s7_sr_q));
        end
      end
    end
  end

  assign min_x_o = s8_min_q[0];
  assign min_y_o = s8_min_q[1];
  assign min_z_o = s8_min_q[2];
  assign max_x_o = s8_max_q[0];
  assign max_y_o = s8_max_q[1];
  assign max_z_o = s8_max_q[2];

`ifndef SYNTH
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during a stall");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transaction not captured");
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[caw_pkg::NumStages-2]) |=> out_valid_o)
    else $error("transaction lost before output");
`endif

endmodule

FILE: src/caw_cfg.sv
`timescale 1ns / 1ps

module caw_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [caw_pkg::AddrWidth-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output caw_pkg::cfg_t                      cfg_o
);

  caw_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        caw_pkg::RegRadius: cfg_d.radius = pwdata[30:0];
        caw_pkg::RegHeight: cfg_d.height = pwdata[30:0];
        caw_pkg::RegAxis:   cfg_d.axis   = pwdata[1:0];
        caw_pkg::RegOffX:   cfg_d.off_x  = pwdata;
        caw_pkg::RegOffY:   cfg_d.off_y  = pwdata;
        caw_pkg::RegOffZ:   cfg_d.off_z  = pwdata;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      caw_pkg::RegRadius: prdata = {1'b0, cfg_q.radius};
      caw_pkg::RegHeight: prdata = {1'b0, cfg_q.height};
      caw_pkg::RegAxis:   prdata = {30'd0, cfg_q.axis};
      caw_pkg::RegOffX:   prdata = cfg_q.off_x;
      caw_pkg::RegOffY:   prdata = cfg_q.off_y;
      caw_pkg::RegOffZ:   prdata = cfg_q.off_z;
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius <= 31'd32768;
      cfg_q.height <= 31'd131072;
      cfg_q.axis   <= caw_pkg::AxisY;
      cfg_q.off_x  <= '0;
      cfg_q.off_y  <= '0;
      cfg_q.off_z  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
